// File: sv/ppm_frame_decode_regenerate_defines.svh
// assertion helpers used by the checker file
`ifndef PPM_FRAME_DECODE_REGENERATE_DEFINES_SVH
`define PPM_FRAME_DECODE_REGENERATE_DEFINES_SVH

// same-cycle implication, reset masks the check
`define PPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ppm check failed");

// next-cycle implication, reset masks the check
`define PPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ppm check failed");

`endif

// File: sv/ppm_pkg.sv
`default_nettype none
package ppm_pkg;

  localparam int SLOT_W = 4;
  localparam int TIME_W = 16;
  localparam int REG_W  = 12;
  localparam int VAL_W  = 16;

  typedef enum logic [1:0] {
    CMD_CAPTURE  = 2'd0,
    CMD_COMPARE  = 2'd1,
    CMD_TIMEOUT  = 2'd2,
    CMD_OVERRIDE = 2'd3
  } ppm_cmd_e;

  typedef enum logic [2:0] {
    REG_LOW_TIME     = 3'd0,
    REG_MIN_HIGH     = 3'd1,
    REG_MAX_HIGH     = 3'd2,
    REG_NEUTRAL_HIGH = 3'd3,
    REG_FRAME_PERIOD = 3'd4,
    REG_WINDOW_SLACK = 3'd5
  } ppm_reg_e;

  // what a compare item adds to the compare time
  typedef enum logic [1:0] {
    CMP_LOST   = 2'd0,
    CMP_LOW    = 2'd1,
    CMP_REMAIN = 2'd2,
    CMP_CHAN   = 2'd3
  } ppm_cmp_e;

  typedef struct packed {
    logic [REG_W-1:0]  low_time;
    logic [REG_W-1:0]  min_high;
    logic [REG_W-1:0]  max_high;
    logic [REG_W-1:0]  neutral_high;
    logic [TIME_W-1:0] frame_period;
    logic [REG_W-1:0]  window_slack;
  } ppm_cfg_t;

  // item state handed from the decode stage to the regenerate stage
  typedef struct packed {
    logic              is_cmp;
    ppm_cmp_e          cmp_mode;
    logic [TIME_W-1:0] compare_time;
    logic              dvalid;
    logic [SLOT_W-1:0] dchan;
    logic [VAL_W-1:0]  dval;
    logic              fsync;
    logic              link_lost;
  } ppm_stage_t;

endpackage
`default_nettype wire

// File: sv/ppm_if.sv
`default_nettype none
interface ppm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] capture_time;
  logic [15:0] compare_time;
  logic [3:0]  override_channel;
  logic signed [15:0] override_value;

  modport source (output valid, command, capture_time, compare_time, override_channel,
                  override_value, input ready);
  modport sink (input valid, command, capture_time, compare_time, override_channel,
                override_value, output ready);
endinterface

interface ppm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] next_compare;
  logic        compare_valid;
  logic        decoded_valid;
  logic [3:0]  decoded_channel;
  logic signed [15:0] decoded_value;
  logic        frame_sync;
  logic        link_lost;

  modport source (output valid, next_compare, compare_valid, decoded_valid, decoded_channel,
                  decoded_value, frame_sync, link_lost, input ready);
  modport sink (input valid, next_compare, compare_valid, decoded_valid, decoded_channel,
                decoded_value, frame_sync, link_lost, output ready);
endinterface
`default_nettype wire

// File: sv/ppm_chan_mem.sv
`default_nettype none
module ppm_chan_mem
  import ppm_pkg::*;
#(
  parameter int DEPTH = 12,
  parameter int IDX_W = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             we_i,
  input  wire logic [IDX_W-1:0] waddr_i,
  input  wire logic [VAL_W-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [IDX_W-1:0] raddr_i,
  output logic      [VAL_W-1:0] rdata_o
);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] entry_vld_q;
  logic [VAL_W-1:0] rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_vld_q <= '0;
      rvld_q      <= 1'b0;
    end else begin
      if (we_i) begin
        entry_vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= entry_vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule
`default_nettype wire

// File: sv/ppm_ctrl.sv
`default_nettype none
module ppm_ctrl
  import ppm_pkg::*;
#(
  parameter int CHANNELS = 12,
  parameter int IDX_W    = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  ppm_in_if.sink          in_if,
  input  wire ppm_cfg_t   cfg_i,
  input  wire logic       b_take_i,
  output logic            b_valid_o,
  output ppm_stage_t      b_o,
  output logic            mem_re_o,
  output logic [IDX_W-1:0] mem_raddr_o,
  output logic            dec_we_o,
  output logic [IDX_W-1:0] dec_waddr_o,
  output logic [VAL_W-1:0] dec_wdata_o,
  output logic            ovr_we_o,
  output logic [IDX_W-1:0] ovr_waddr_o,
  output logic [VAL_W-1:0] ovr_wdata_o
);

  localparam logic [SLOT_W-1:0] ChanSlot = SLOT_W'(CHANNELS);
  localparam logic signed [19:0] ChanMul = 20'(CHANNELS);

  logic [TIME_W-1:0] last_edge_q, last_edge_d;
  logic [SLOT_W-1:0] in_slot_q, in_slot_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic              phase_q, phase_d;
  logic              lost_q, lost_d;
  logic              b_valid_q, b_valid_d;
  ppm_stage_t        b_q, b_d;

  logic              accept;
  ppm_cmd_e          cmd;
  logic [TIME_W-1:0] iv;
  logic signed [19:0] iv_s, lo_s, mn_s, mx_s, nt_s, fp_s, sl_s;
  logic signed [19:0] smin_s, smax_s, dv_s, ov_s, lob_s, hib_s, ovc_s;
  logic              is_sync, is_pulse, in_open;
  logic [VAL_W-1:0]  dval_sat;

  assign accept      = in_if.valid && in_if.ready;
  assign in_if.ready = !b_valid_q || b_take_i;
  assign cmd         = ppm_cmd_e'(in_if.command);

  // window arithmetic in a 20-bit signed domain
  assign iv   = in_if.capture_time - last_edge_q;
  assign iv_s = signed'(20'(iv));
  assign lo_s = signed'(20'(cfg_i.low_time));
  assign mn_s = signed'(20'(cfg_i.min_high));
  assign mx_s = signed'(20'(cfg_i.max_high));
  assign nt_s = signed'(20'(cfg_i.neutral_high));
  assign fp_s = signed'(20'(cfg_i.frame_period));
  assign sl_s = signed'(20'(cfg_i.window_slack));

  assign smin_s = fp_s - lo_s - (lo_s + mx_s) * ChanMul;
  assign smax_s = fp_s - lo_s - (lo_s + mn_s) * ChanMul;

  assign is_sync  = (iv_s > smin_s - sl_s) && (iv_s < smax_s + sl_s);
  assign is_pulse = (iv_s > lo_s + mn_s - sl_s) && (iv_s < lo_s + mx_s + sl_s);
  assign in_open  = in_slot_q < ChanSlot;

  assign dv_s     = iv_s - lo_s - nt_s;
  assign dval_sat = (dv_s > 20'sd32767) ? 16'h7FFF : dv_s[VAL_W-1:0];

  // override clamp, lower bound wins
  assign ov_s  = {{4{in_if.override_value[VAL_W-1]}}, in_if.override_value};
  assign lob_s = mn_s - nt_s;
  assign hib_s = mx_s - nt_s;
  always_comb begin
    if (ov_s < lob_s) begin
      ovc_s = lob_s;
    end else if (ov_s > hib_s) begin
      ovc_s = hib_s;
    end else begin
      ovc_s = ov_s;
    end
  end

  always_comb begin
    last_edge_d = last_edge_q;
    in_slot_d   = in_slot_q;
    out_slot_d  = out_slot_q;
    phase_d     = phase_q;
    lost_d      = lost_q;
    dec_we_o    = 1'b0;
    ovr_we_o    = 1'b0;
    b_d         = '0;
    b_d.cmp_mode     = CMP_LOST;
    b_d.compare_time = in_if.compare_time;
    unique case (cmd)
      CMD_CAPTURE: begin
        last_edge_d = in_if.capture_time;
        lost_d      = 1'b0;
        if (is_sync) begin
          in_slot_d = '0;
          b_d.fsync = 1'b1;
        end else if (in_open && is_pulse) begin
          dec_we_o   = accept;
          b_d.dvalid = 1'b1;
          b_d.dchan  = in_slot_q;
          b_d.dval   = dval_sat;
          in_slot_d  = in_slot_q + 1'b1;
        end
      end
      CMD_COMPARE: begin
        b_d.is_cmp = 1'b1;
        if (lost_q) begin
          b_d.cmp_mode = CMP_LOST;
        end else if (!phase_q) begin
          b_d.cmp_mode = CMP_LOW;
          phase_d      = 1'b1;
        end else if (out_slot_q >= ChanSlot) begin
          b_d.cmp_mode = CMP_REMAIN;
          out_slot_d   = '0;
          phase_d      = 1'b0;
        end else begin
          b_d.cmp_mode = CMP_CHAN;
          out_slot_d   = out_slot_q + 1'b1;
          phase_d      = 1'b0;
        end
      end
      CMD_TIMEOUT: begin
        lost_d = 1'b1;
      end
      CMD_OVERRIDE: begin
        ovr_we_o = accept && (in_if.override_channel < ChanSlot);
      end
      default: begin
        lost_d = lost_q;
      end
    endcase
    b_d.link_lost = lost_d;
  end

  assign dec_waddr_o = in_slot_q[IDX_W-1:0];
  assign dec_wdata_o = dval_sat;
  assign ovr_waddr_o = in_if.override_channel[IDX_W-1:0];
  assign ovr_wdata_o = ovc_s[VAL_W-1:0];

  // channel data for a compare item is read as it is accepted
  assign mem_re_o    = accept;
  assign mem_raddr_o = (out_slot_q < ChanSlot) ? out_slot_q[IDX_W-1:0] : '0;

  always_comb begin
    if (accept) begin
      b_valid_d = 1'b1;
    end else if (b_take_i) begin
      b_valid_d = 1'b0;
    end else begin
      b_valid_d = b_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_edge_q <= '0;
      in_slot_q   <= ChanSlot;
      out_slot_q  <= ChanSlot;
      phase_q     <= 1'b0;
      lost_q      <= 1'b0;
      b_valid_q   <= 1'b0;
    end else begin
      b_valid_q <= b_valid_d;
      if (accept) begin
        last_edge_q <= last_edge_d;
        in_slot_q   <= in_slot_d;
        out_slot_q  <= out_slot_d;
        phase_q     <= phase_d;
        lost_q      <= lost_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_q <= b_d;
    end
  end

  assign b_valid_o = b_valid_q;
  assign b_o       = b_q;

endmodule
`default_nettype wire

// File: sv/ppm_regen.sv
`default_nettype none
module ppm_regen
  import ppm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ppm_cfg_t         cfg_i,
  input  wire logic             b_valid_i,
  input  wire ppm_stage_t       b_i,
  input  wire logic [VAL_W-1:0] dec_rd_i,
  input  wire logic [VAL_W-1:0] ovr_rd_i,
  output logic                  b_take_o,
  ppm_out_if.source             out_if
);

  logic [TIME_W-1:0] elapsed_q, elapsed_d;
  logic [TIME_W-1:0] add, width, next;
  logic              b_move;

  logic              out_valid_q;
  logic [TIME_W-1:0] next_q;
  logic              cvalid_q;
  logic              dvalid_q;
  logic [SLOT_W-1:0] dchan_q;
  logic [VAL_W-1:0]  dval_q;
  logic              fsync_q;
  logic              lost_q;

  // a nonzero override replaces the decoded width
  assign width = ((ovr_rd_i != '0) ? ovr_rd_i : dec_rd_i) + TIME_W'(cfg_i.neutral_high);

  always_comb begin
    elapsed_d = elapsed_q;
    add       = '0;
    case (b_i.cmp_mode)
      CMP_LOST: begin
        add = cfg_i.frame_period;
      end
      CMP_LOW: begin
        add       = TIME_W'(cfg_i.low_time);
        elapsed_d = elapsed_q + add;
      end
      CMP_REMAIN: begin
        add       = cfg_i.frame_period - elapsed_q;
        elapsed_d = '0;
      end
      CMP_CHAN: begin
        add       = width;
        elapsed_d = elapsed_q + add;
      end
      default: begin
        add = '0;
      end
    endcase
  end

  assign next     = b_i.compare_time + add;
  assign b_take_o = !out_valid_q || out_if.ready;
  assign b_move   = b_valid_i && b_take_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      elapsed_q   <= '0;
    end else begin
      if (b_move) begin
        out_valid_q <= 1'b1;
        if (b_i.is_cmp) begin
          elapsed_q <= elapsed_d;
        end
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_move) begin
      next_q   <= b_i.is_cmp ? next : '0;
      cvalid_q <= b_i.is_cmp;
      dvalid_q <= b_i.dvalid;
      dchan_q  <= b_i.dchan;
      dval_q   <= b_i.dval;
      fsync_q  <= b_i.fsync;
      lost_q   <= b_i.link_lost;
    end
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.next_compare    = next_q;
  assign out_if.compare_valid   = cvalid_q;
  assign out_if.decoded_valid   = dvalid_q;
  assign out_if.decoded_channel = dchan_q;
  assign out_if.decoded_value   = dval_q;
  assign out_if.frame_sync      = fsync_q;
  assign out_if.link_lost       = lost_q;

endmodule
`default_nettype wire

// File: sv/ppm_frame_decode_regenerate.sv
// an accepted item is registered in the decode stage, then in the regenerate stage
// throughput: one item per cycle while results are taken; each channel store has one
//   write and one read port, the compare read is issued as the item is accepted and
//   consumed in the regenerate stage
// reset: control state clears at once, both channel stores read as zero through
//   per-entry valid bits, so items are taken as soon as reset is released
`default_nettype none
module ppm_frame_decode_regenerate
  import ppm_pkg::*;
#(
  parameter int CHANNELS = 12
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ppm_in_if.sink           in_if,
  ppm_out_if.source        out_if,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i
);

  localparam int IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  ppm_cfg_t   cfg_q;
  logic       b_valid, b_take;
  ppm_stage_t b_stage;
  logic       mem_re;
  logic [IdxW-1:0] mem_raddr, dec_waddr, ovr_waddr;
  logic       dec_we, ovr_we;
  logic [VAL_W-1:0] dec_wdata, ovr_wdata, dec_rd, ovr_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_time     <= 12'd520;
      cfg_q.min_high     <= 12'd600;
      cfg_q.max_high     <= 12'd1400;
      cfg_q.neutral_high <= 12'd1000;
      cfg_q.frame_period <= 16'd30000;
      cfg_q.window_slack <= 12'd200;
    end else if (cfg_we_i) begin
      unique case (ppm_reg_e'(cfg_idx_i))
        REG_LOW_TIME:     cfg_q.low_time     <= cfg_wdata_i[REG_W-1:0];
        REG_MIN_HIGH:     cfg_q.min_high     <= cfg_wdata_i[REG_W-1:0];
        REG_MAX_HIGH:     cfg_q.max_high     <= cfg_wdata_i[REG_W-1:0];
        REG_NEUTRAL_HIGH: cfg_q.neutral_high <= cfg_wdata_i[REG_W-1:0];
        REG_FRAME_PERIOD: cfg_q.frame_period <= cfg_wdata_i;
        REG_WINDOW_SLACK: cfg_q.window_slack <= cfg_wdata_i[REG_W-1:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  ppm_ctrl #(
    .CHANNELS (CHANNELS),
    .IDX_W    (IdxW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .cfg_i       (cfg_q),
    .b_take_i    (b_take),
    .b_valid_o   (b_valid),
    .b_o         (b_stage),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .dec_we_o    (dec_we),
    .dec_waddr_o (dec_waddr),
    .dec_wdata_o (dec_wdata),
    .ovr_we_o    (ovr_we),
    .ovr_waddr_o (ovr_waddr),
    .ovr_wdata_o (ovr_wdata)
  );

  ppm_chan_mem #(
    .DEPTH (CHANNELS),
    .IDX_W (IdxW)
  ) u_dec_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (dec_we),
    .waddr_i (dec_waddr),
    .wdata_i (dec_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (dec_rd)
  );

  ppm_chan_mem #(
    .DEPTH (CHANNELS),
    .IDX_W (IdxW)
  ) u_ovr_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (ovr_we),
    .waddr_i (ovr_waddr),
    .wdata_i (ovr_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (ovr_rd)
  );

  ppm_regen u_regen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .b_valid_i (b_valid),
    .b_i       (b_stage),
    .dec_rd_i  (dec_rd),
    .ovr_rd_i  (ovr_rd),
    .b_take_o  (b_take),
    .out_if    (out_if)
  );

endmodule
`default_nettype wire

// File: sv/ppm_chk.sv
`default_nettype none
`include "ppm_frame_decode_regenerate_defines.svh"
module ppm_chk #(
  parameter int CHANNELS = 12
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [15:0] next_compare_i,
  input wire logic        compare_valid_i,
  input wire logic        decoded_valid_i,
  input wire logic [3:0]  decoded_channel_i,
  input wire logic        frame_sync_i
);

  // a result is never both a compare reply and a capture report
  `PPM_ASSERT_IMP(a_kind_excl, clk_i, rst_ni, out_valid_i,
                  !(compare_valid_i && (decoded_valid_i || frame_sync_i)))

  // a sync gap stores no channel value
  `PPM_ASSERT_IMP(a_sync_no_value, clk_i, rst_ni, out_valid_i && frame_sync_i,
                  !decoded_valid_i && (decoded_channel_i == 4'd0))

  // only real slots are reported
  `PPM_ASSERT_IMP(a_chan_range, clk_i, rst_ni, out_valid_i && decoded_valid_i,
                  decoded_channel_i < 4'(CHANNELS))

  // a stalled result holds
  `PPM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(next_compare_i) && $stable(compare_valid_i))

endmodule

bind ppm_frame_decode_regenerate ppm_chk #(
  .CHANNELS (CHANNELS)
) u_ppm_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_if.valid),
  .out_ready_i       (out_if.ready),
  .next_compare_i    (out_if.next_compare),
  .compare_valid_i   (out_if.compare_valid),
  .decoded_valid_i   (out_if.decoded_valid),
  .decoded_channel_i (out_if.decoded_channel),
  .frame_sync_i      (out_if.frame_sync)
);
`default_nettype wire
